/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property a implies b on the same clock edge.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: implication violated");

// Condition a must never be seen.
`define ASSERT_NEVER(label, clk, rst_n, a) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(a)) \
        else $error("assertion failed: forbidden condition seen");

// Condition a at one edge implies b at the next.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: next-cycle condition violated");

`endif

/* rtl/jsu_pkg.sv */
// Types, character codes and helper functions for the string unescaper.
`default_nettype none

package jsu_pkg;

    localparam int RES_MAX = 3;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_NO_QUOTE = 2'd1;
    localparam logic [1:0] ERR_EOF      = 2'd2;

    localparam logic [2:0] HEX_DIGITS   = 3'd4;
    localparam logic [4:0] NIB_NONE     = 5'd16;

    typedef enum logic [3:0] {
        MODE_IDLE   = 4'b0001,
        MODE_STRING = 4'b0010,
        MODE_ESCAPE = 4'b0100,
        MODE_HEX    = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_last;
        logic [1:0] error_code;
    } res_t;

    typedef struct packed {
        res_t [RES_MAX-1:0] res;
        logic [1:0]         count;
    } group_t;

    function automatic res_t mk_res(logic [7:0] b, logic last, logic [1:0] err);
        res_t r;
        r.out_byte   = b;
        r.is_last    = last;
        r.error_code = err;
        return r;
    endfunction

    // 0..15 for a hex digit, NIB_NONE otherwise
    function automatic logic [4:0] hex_nibble(logic [7:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39)
            v = 5'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66)
            v = 5'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46)
            v = 5'(c - 8'h37);
        else
            v = NIB_NONE;
        return v;
    endfunction

    function automatic logic [7:0] esc_map(logic [7:0] c);
        logic [7:0] d;
        case (c)
            CH_B:    d = 8'h08;
            CH_F:    d = 8'h0C;
            CH_N:    d = 8'h0A;
            CH_R:    d = 8'h0D;
            CH_T:    d = 8'h09;
            default: d = c;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

/* rtl/jsu_if.sv */
// Valid/ready channel interfaces for raw input bytes and decoded results.
`default_nettype none

interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_last;
    logic [1:0] error_code;

    modport source (output valid, output out_byte, output is_last, output error_code,
                    input ready);
    modport sink   (input valid, input out_byte, input is_last, input error_code,
                    output ready);
endinterface

`default_nettype wire

/* rtl/jsu_decoder.sv */
// Mode state and per-byte decode into a group of up to three results.
`default_nettype none

module jsu_decoder
    import jsu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] in_byte,
    input  wire logic       end_of_input,
    output group_t          group
);

    mode_t       mode_reg, mode_next;
    logic [2:0]  hex_count_reg, hex_count_next;
    logic [15:0] hex_value_reg, hex_value_next;
    logic        hex_stopped_reg, hex_stopped_next;

    logic [4:0]  nib;
    logic [2:0]  count_inc;
    logic [1:0]  n;
    res_t [RES_MAX-1:0] r;

    always_comb
    begin
        mode_next        = mode_reg;
        hex_count_next   = hex_count_reg;
        hex_value_next   = hex_value_reg;
        hex_stopped_next = hex_stopped_reg;
        nib              = hex_nibble(in_byte);
        count_inc        = hex_count_reg + 3'd1;
        n                = 2'd0;
        r                = '0;

        case (mode_reg)
            MODE_IDLE:
            begin
                if (in_byte == CH_QUOTE)
                    mode_next = MODE_STRING;
                else
                begin
                    r[0] = mk_res(8'h00, 1'b1, ERR_NO_QUOTE);
                    n    = 2'd1;
                end
            end
            MODE_STRING:
            begin
                if (in_byte == CH_BACKSLASH)
                    mode_next = MODE_ESCAPE;
                else if (in_byte == CH_QUOTE)
                begin
                    r[0]      = mk_res(8'h00, 1'b1, ERR_NONE);
                    n         = 2'd1;
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    r[0] = mk_res(in_byte, 1'b0, ERR_NONE);
                    n    = 2'd1;
                end
            end
            MODE_ESCAPE:
            begin
                if (in_byte == CH_U)
                begin
                    hex_count_next   = 3'd0;
                    hex_value_next   = 16'h0000;
                    hex_stopped_next = 1'b0;
                    mode_next        = MODE_HEX;
                end
                else
                begin
                    r[0]      = mk_res(esc_map(in_byte), 1'b0, ERR_NONE);
                    n         = 2'd1;
                    mode_next = MODE_STRING;
                end
            end
            MODE_HEX:
            begin
                // accumulation stops for good at the first non-hex byte
                if (!hex_stopped_reg && nib != NIB_NONE)
                    hex_value_next = {hex_value_reg[11:0], nib[3:0]};
                else
                    hex_stopped_next = 1'b1;
                hex_count_next = count_inc;
                if (count_inc >= HEX_DIGITS)
                begin
                    r[0]             = mk_res(hex_value_next[15:8], 1'b0, ERR_NONE);
                    r[1]             = mk_res(hex_value_next[7:0], 1'b0, ERR_NONE);
                    n                = 2'd2;
                    hex_count_next   = 3'd0;
                    hex_value_next   = 16'h0000;
                    hex_stopped_next = 1'b0;
                    mode_next        = MODE_STRING;
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase

        // input ran out inside a string: append the eof result
        if (end_of_input && mode_next != MODE_IDLE)
        begin
            r[n]             = mk_res(8'h00, 1'b1, ERR_EOF);
            n                = n + 2'd1;
            mode_next        = MODE_IDLE;
            hex_count_next   = 3'd0;
            hex_value_next   = 16'h0000;
            hex_stopped_next = 1'b0;
        end

        group.res   = r;
        group.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_IDLE;
            hex_count_reg   <= 3'd0;
            hex_value_reg   <= 16'h0000;
            hex_stopped_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg        <= mode_next;
            hex_count_reg   <= hex_count_next;
            hex_value_reg   <= hex_value_next;
            hex_stopped_reg <= hex_stopped_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/jsu_result_queue.sv */
// Result register: holds one group of results and hands them out one per cycle while out_ch is ready.
`default_nettype none

module jsu_result_queue
    import jsu_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  load,
    input  group_t     group,
    output logic       ready,
    jsu_out_if.source  out_ch
);

    res_t [RES_MAX-1:0] res_reg;
    logic [1:0]         count_reg, count_next;
    logic [1:0]         idx_reg, idx_next;
    logic               pop, last_pop;
    res_t               cur;

    assign cur      = res_reg[idx_reg];
    assign pop      = out_ch.valid && out_ch.ready;
    assign last_pop = pop && (idx_reg == count_reg - 2'd1);
    // a new item may enter as the last result of the group leaves
    assign ready    = (count_reg == 2'd0) || last_pop;

    assign out_ch.valid      = (count_reg != 2'd0);
    assign out_ch.out_byte   = cur.out_byte;
    assign out_ch.is_last    = cur.is_last;
    assign out_ch.error_code = cur.error_code;

    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            count_next = group.count;
            idx_next   = 2'd0;
        end
        else if (last_pop)
        begin
            count_next = 2'd0;
            idx_next   = 2'd0;
        end
        else if (pop)
            idx_next = idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= group.res;
    end

endmodule

`default_nettype wire

/* rtl/json_string_unescaper_unit.sv */
// Top level of the quoted-string unescaper.
// Usage:
//   in_ch  takes one raw byte of quoted string text per item, with
//          end_of_input marking the last byte available.
//   out_ch gives decoded bytes one per item: out_byte, is_last, error_code.
//   An item yields zero to three results: an opening quote or a backslash
//   yields none, a completed \u escape yields two, and input ending inside
//   a string appends an eof result.
// The first result of an item is offered the cycle after it is accepted.
//   Items are taken one per cycle while each yields at most one result and
//   out_ch is ready; an item with more results holds off the next until the
//   single result register drains them onto out_ch, one per ready cycle.
// Reset: decoder returns to idle awaiting an opening quote and the result
//   register empties; nothing is offered until an item arrives.
// Stall: while out_ch is not ready the pending result holds steady and
//   in_ch.ready stays low until the last result of the group is taken.
`default_nettype none

module json_string_unescaper_unit
    import jsu_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    jsu_in_if.sink    in_ch,
    jsu_out_if.source out_ch
);

    group_t group;
    logic   ready;
    logic   accept;
    logic   load;

    assign in_ch.ready = ready;
    assign accept      = in_ch.valid && ready;
    assign load        = accept && (group.count != 2'd0);

    jsu_decoder u_decoder (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .in_byte      (in_ch.in_byte),
        .end_of_input (in_ch.end_of_input),
        .group        (group)
    );

    jsu_result_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .group  (group),
        .ready  (ready),
        .out_ch (out_ch)
    );

endmodule

`default_nettype wire

/* rtl/jsu_checker.sv */
// Port-level checks on the unescaper's result channel, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module jsu_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       is_last,
    input wire logic [1:0] error_code
);

    // a stalled result stays offered
    `ASSERT_NEXT(a_hold_valid, clk, rst_n, out_valid && !out_ready, out_valid)

    // every error ends the string with a zero byte
    `ASSERT_IMPLIES(a_err_is_last, clk, rst_n, out_valid && error_code != 2'd0,
                    is_last && out_byte == 8'h00)

    // the terminator carries a zero byte
    `ASSERT_IMPLIES(a_term_zero, clk, rst_n, out_valid && is_last, out_byte == 8'h00)

    `ASSERT_NEVER(a_err_code_range, clk, rst_n, out_valid && error_code == 2'd3)

endmodule

bind json_string_unescaper_unit jsu_checker u_jsu_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_byte   (out_ch.out_byte),
    .is_last    (out_ch.is_last),
    .error_code (out_ch.error_code)
);

`default_nettype wire

/* tb/json_string_unescaper_unit_tb.sv */
// Self-checking testbench for the quoted-string unescaper, with random handshake gaps.
`timescale 1ns / 1ps

module json_string_unescaper_unit_tb;
    import jsu_pkg::*;

    localparam int RANDOM_ITEMS = 320;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [7:0] b;
        logic       eoi;
    } raw_item_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // block inputs, known from time zero
    logic       drv_valid = 1'b0;
    logic [7:0] drv_byte  = 8'h00;
    logic       drv_eoi   = 1'b0;
    logic       drv_ready = 1'b0;

    jsu_in_if  in_ch ();
    jsu_out_if out_ch ();

    assign in_ch.valid        = drv_valid;
    assign in_ch.in_byte      = drv_byte;
    assign in_ch.end_of_input = drv_eoi;
    assign out_ch.ready       = drv_ready;

    json_string_unescaper_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #4 clk = ~clk;

    raw_item_t raw_q[$];
    res_t      decoded_q[$];

    // decoder state as predicted
    mode_t       dec_mode = MODE_IDLE;
    logic [2:0]  hex_cnt  = '0;
    logic [15:0] hex_acc  = '0;
    logic        hex_halt = 1'b0;

    int        total_items  = 0;
    int        accepted_cnt = 0;
    int        mismatch_cnt = 0;
    int        quiet_cycles = 0;
    logic      in_fire      = 1'b0;
    int        in_gap       = 0;
    int        in_calm      = 0;
    int        out_stall    = 0;
    int        out_calm     = 0;
    raw_item_t next_raw;

    string HEX_CHARS = "0123456789abcdefABCDEF";

    function automatic logic [4:0] hex_digit_val(logic [7:0] c);
        if (c >= "0" && c <= "9")
            return {1'b0, 4'(c - "0")};
        if (c >= "a" && c <= "f")
            return {1'b0, 4'(c - "a" + 8'd10)};
        if (c >= "A" && c <= "F")
            return {1'b0, 4'(c - "A" + 8'd10)};
        return 5'd16;
    endfunction

    function automatic void push_decoded(logic [7:0] b, logic last, logic [1:0] err);
        res_t r;
        r.out_byte   = b;
        r.is_last    = last;
        r.error_code = err;
        decoded_q.push_back(r);
    endfunction

    function automatic void clear_hex();
        hex_cnt  = '0;
        hex_acc  = '0;
        hex_halt = 1'b0;
    endfunction

    function automatic void decode_byte(logic [7:0] c, logic eoi);
        logic [4:0] nib;
        logic [7:0] d;
        case (dec_mode)
            MODE_IDLE:
            begin
                if (c == CH_QUOTE)
                    dec_mode = MODE_STRING;
                else
                begin
                    // stays idle, end of input adds nothing here
                    push_decoded(8'h00, 1'b1, ERR_NO_QUOTE);
                    return;
                end
            end
            MODE_STRING:
            begin
                if (c == CH_BACKSLASH)
                    dec_mode = MODE_ESCAPE;
                else if (c == CH_QUOTE)
                begin
                    push_decoded(8'h00, 1'b1, ERR_NONE);
                    dec_mode = MODE_IDLE;
                end
                else
                    push_decoded(c, 1'b0, ERR_NONE);
            end
            MODE_ESCAPE:
            begin
                if (c == CH_U)
                begin
                    clear_hex();
                    dec_mode = MODE_HEX;
                end
                else
                begin
                    case (c)
                        CH_B:    d = 8'h08;
                        CH_F:    d = 8'h0C;
                        CH_N:    d = 8'h0A;
                        CH_R:    d = 8'h0D;
                        CH_T:    d = 8'h09;
                        default: d = c;
                    endcase
                    push_decoded(d, 1'b0, ERR_NONE);
                    dec_mode = MODE_STRING;
                end
            end
            default:
            begin
                // four bytes consumed unless input ends first; accumulation halts at first non-hex
                nib = hex_digit_val(c);
                if (!hex_halt && nib < 5'd16)
                    hex_acc = {hex_acc[11:0], nib[3:0]};
                else
                    hex_halt = 1'b1;
                hex_cnt = hex_cnt + 3'd1;
                if (hex_cnt >= HEX_DIGITS)
                begin
                    push_decoded(hex_acc[15:8], 1'b0, ERR_NONE);
                    push_decoded(hex_acc[7:0], 1'b0, ERR_NONE);
                    clear_hex();
                    dec_mode = MODE_STRING;
                end
            end
        endcase
        if (eoi && dec_mode != MODE_IDLE)
        begin
            push_decoded(8'h00, 1'b1, ERR_EOF);
            dec_mode = MODE_IDLE;
            clear_hex();
        end
    endfunction

    function automatic void check_result(res_t got);
        res_t want;
        if (decoded_q.size() == 0)
        begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
                $display("unexpected result: byte %02h last %0b err %0d",
                         got.out_byte, got.is_last, got.error_code);
            return;
        end
        want = decoded_q.pop_front();
        if (got.out_byte !== want.out_byte || got.is_last !== want.is_last ||
            got.error_code !== want.error_code)
        begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
                $display("mismatch: expected %02h/%0b/%0d, got %02h/%0b/%0d",
                         want.out_byte, want.is_last, want.error_code,
                         got.out_byte, got.is_last, got.error_code);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // handshake sampling, prediction, checking and watchdog
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_fire <= 1'b0;
        else
        begin
            in_fire <= in_ch.valid && in_ch.ready;
            if (out_ch.valid && out_ch.ready)
                check_result({out_ch.out_byte, out_ch.is_last, out_ch.error_code});
            if (in_ch.valid && in_ch.ready)
            begin
                decode_byte(in_ch.in_byte, in_ch.end_of_input);
                accepted_cnt++;
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // driver for both channels, changes at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!drv_valid || in_fire)
            begin
                if (in_gap > 0)
                begin
                    drv_valid <= 1'b0;
                    in_gap = in_gap - 1;
                end
                else if (raw_q.size() != 0)
                begin
                    next_raw = raw_q.pop_front();
                    drv_byte  <= next_raw.b;
                    drv_eoi   <= next_raw.eoi;
                    drv_valid <= 1'b1;
                    if (in_calm > 0)
                    begin
                        in_calm--;
                        in_gap = 0;
                    end
                    else
                    begin
                        in_gap = pick_gap();
                        if ($urandom_range(0, 39) == 0)
                            in_calm = 30;
                    end
                end
                else
                    drv_valid <= 1'b0;
            end

            if (out_stall > 0)
            begin
                drv_ready <= 1'b0;
                out_stall = out_stall - 1;
            end
            else
            begin
                drv_ready <= 1'b1;
                if (out_calm > 0)
                    out_calm--;
                else if ($urandom_range(0, 3) == 0)
                    out_stall = pick_gap();
                else if ($urandom_range(0, 59) == 0)
                    out_calm = 40;
            end
        end
    end

    function automatic void push_byte(logic [7:0] b, logic eoi = 1'b0);
        raw_item_t it;
        it.b   = b;
        it.eoi = eoi;
        raw_q.push_back(it);
    endfunction

    function automatic void push_text(string s, logic eoi_last = 1'b0);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], (i == s.len() - 1) ? eoi_last : 1'b0);
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_QUOTE || b == CH_BACKSLASH);
        return b;
    endfunction

    function automatic logic [7:0] hex_or_junk();
        if ($urandom_range(0, 99) < 85)
            return HEX_CHARS[$urandom_range(0, 21)];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void push_element();
        int         e;
        logic [7:0] c;
        e = $urandom_range(0, 9);
        if (e < 5)
            push_byte(plain_byte());
        else if (e < 7)
        begin
            push_byte(CH_BACKSLASH);
            case ($urandom_range(0, 8))
                0: c = CH_B;
                1: c = CH_F;
                2: c = CH_N;
                3: c = CH_R;
                4: c = CH_T;
                5: c = CH_QUOTE;
                6: c = CH_BACKSLASH;
                default:
                begin
                    do
                        c = 8'($urandom_range(0, 255));
                    while (c == CH_U);
                end
            endcase
            push_byte(c);
        end
        else
        begin
            push_byte(CH_BACKSLASH);
            push_byte(CH_U);
            repeat (4) push_byte(hex_or_junk());
        end
    endfunction

    function automatic void push_random_group();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 12)
        begin
            // stray bytes while idle
            repeat ($urandom_range(1, 3))
                push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            return;
        end
        push_byte(CH_QUOTE);
        n = $urandom_range(0, 8);
        repeat (n) push_element();
        if (kind < 32)
        begin
            // input cut short, sometimes in the middle of an escape
            case ($urandom_range(0, 3))
                0: push_byte(CH_BACKSLASH);
                1:
                begin
                    push_byte(CH_BACKSLASH);
                    push_byte(CH_U);
                    repeat ($urandom_range(0, 3)) push_byte(hex_or_junk());
                end
                default: ;
            endcase
            raw_q[$].eoi = 1'b1;
        end
        else
            push_byte(CH_QUOTE, $urandom_range(0, 5) == 0);
    endfunction

    initial
    begin
        // directed: idle errors, byte extremes, escapes, hex, end-of-input cases
        push_byte(8'h00);
        push_byte(8'hFF, 1'b1);
        push_byte(CH_QUOTE);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_text("\\b\\f\\n\\r\\t\\\\");
        push_text("\\uFf00");
        push_text("\\uAg\"1");
        push_byte(CH_QUOTE, 1'b1);
        push_byte(CH_QUOTE, 1'b1);
        push_text("\"\\", 1'b1);
        push_text("\"\\u7", 1'b1);

        while (raw_q.size() < RANDOM_ITEMS)
            push_random_group();
        total_items = raw_q.size();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (accepted_cnt < total_items || decoded_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0 && decoded_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/jsu_pkg.sv
rtl/jsu_if.sv
rtl/jsu_decoder.sv
rtl/jsu_result_queue.sv
rtl/json_string_unescaper_unit.sv
rtl/jsu_checker.sv
tb/json_string_unescaper_unit_tb.sv
